// ===== rtl/ddc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddc_pkg
// Shared types and constants for the disciplined day clock.
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

	localparam int unsigned TIME_W = 27;
	localparam int unsigned TICK_W = 14;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned DIFF_W = TIME_W + 1;

	localparam logic [TIME_W-1:0] DAY_MS     = TIME_W'(86_400_000);
	localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(10_000);

	// signed bounds on the raw reference-minus-clock difference
	localparam logic signed [DIFF_W-1:0] NEAR_POS = DIFF_W'(10_000);
	localparam logic signed [DIFF_W-1:0] NEAR_NEG = -DIFF_W'(10_000);
	localparam logic signed [DIFF_W-1:0] FAR_POS  = DIFF_W'(86_400_000 - 10_000);
	localparam logic signed [DIFF_W-1:0] FAR_NEG  = -DIFF_W'(86_400_000 - 10_000);

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_UP   = 2'b01;
	localparam logic [1:0] DIR_DOWN = 2'b11;

	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] reference_ms;
	} item_t;

	typedef struct packed {
		logic [WORD_W-1:0] rate_offset;
		logic [TIME_W-1:0] time_of_day_ms;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/ddc_in_reg.sv =====
// ----------------------------------------------------------------------------
// ddc_in_reg
// Input register for accepted words; releases one word when the next stage
// advances.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_in_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ddc_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output ddc_pkg::item_t     item_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ddc_update.sv =====
// ----------------------------------------------------------------------------
// ddc_update
// Clock state, rate and phase correction, and the next-state logic for one
// tick or set-time word.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_update (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic          enable,
	input  wire ddc_pkg::item_t item,
	output ddc_pkg::result_t   result
);

	localparam int unsigned TW = ddc_pkg::TIME_W;
	localparam int unsigned KW = ddc_pkg::TICK_W;
	localparam int unsigned WW = ddc_pkg::WORD_W;
	localparam int unsigned DW = ddc_pkg::DIFF_W;

	logic [TW-1:0] clock_q,  clock_n;
	logic [KW-1:0] ticks_q,  ticks_n;
	logic [WW-1:0] numer_q,  numer_n;
	logic [KW-1:0] denom_q,  denom_n;
	logic [1:0]    dir_q,    dir_n;
	logic [WW-1:0] acc_q,    acc_n;
	logic [WW-1:0] phase_q,  phase_n;
	logic [WW-1:0] last_q,   last_n;

	logic [WW-1:0]        acc_dec;
	logic [1:0]           step;
	logic [TW:0]          clock_sum;
	logic [TW-1:0]        ref_red;
	logic signed [DW-1:0] diff;
	logic                 near;
	logic [WW-1:0]        ref_low;
	logic [WW-1:0]        dms;
	logic [WW-1:0]        num;
	logic                 below_limit;
	logic                 discipline;

	assign below_limit = ticks_q < ddc_pkg::TICK_LIMIT;
	assign acc_dec     = acc_q - numer_q;
	assign ref_red     = (item.reference_ms >= ddc_pkg::DAY_MS) ?
		item.reference_ms - ddc_pkg::DAY_MS : item.reference_ms;
	assign diff        = $signed({1'b0, ref_red}) - $signed({1'b0, clock_q});
	assign near        = (diff > ddc_pkg::NEAR_NEG && diff < ddc_pkg::NEAR_POS) ||
		diff > ddc_pkg::FAR_POS || diff < ddc_pkg::FAR_NEG;
	assign ref_low     = item.reference_ms[WW-1:0];
	assign dms         = ref_low - last_q;
	assign num         = dms - WW'(ticks_q);
	assign discipline  = below_limit && !dms[WW-1] && (dms != '0) && near;

	always_comb begin
		clock_n   = clock_q;
		ticks_n   = ticks_q;
		numer_n   = numer_q;
		denom_n   = denom_q;
		dir_n     = dir_q;
		acc_n     = acc_q;
		phase_n   = phase_q;
		last_n    = last_q;
		step      = 2'd1;
		clock_sum = '0;
		if (item.command == ddc_pkg::CMD_TICK) begin
			if (below_limit) begin
				ticks_n = ticks_q + KW'(1);
			end
			acc_n = acc_dec;
			if (acc_dec[WW-1]) begin
				acc_n = acc_dec + WW'(denom_q);
				unique case (dir_q)
					ddc_pkg::DIR_UP:   step = 2'd2;
					ddc_pkg::DIR_DOWN: step = 2'd0;
					default:           step = 2'd1;
				endcase
			end else if (!phase_q[WW-1] && phase_q != '0) begin
				step    = 2'd2;
				phase_n = phase_q - WW'(1);
			end else if (phase_q[WW-1]) begin
				step    = 2'd0;
				phase_n = phase_q + WW'(1);
			end
			clock_sum = {1'b0, clock_q} + (TW+1)'(step);
			clock_n   = (clock_sum >= {1'b0, ddc_pkg::DAY_MS}) ?
				TW'(clock_sum - {1'b0, ddc_pkg::DAY_MS}) : clock_sum[TW-1:0];
		end else if (enable) begin
			if (discipline) begin
				denom_n = ticks_q;
				if (!num[WW-1]) begin
					numer_n = num;
					dir_n   = ddc_pkg::DIR_UP;
				end else begin
					numer_n = -num;
					dir_n   = ddc_pkg::DIR_DOWN;
				end
				phase_n = ref_low - clock_q[WW-1:0];
			end else begin
				clock_n = ref_red;
			end
			last_n  = ref_low;
			ticks_n = '0;
		end
	end

	always_comb begin
		result.time_of_day_ms = clock_n;
		unique case (dir_n)
			ddc_pkg::DIR_UP:   result.rate_offset = numer_n;
			ddc_pkg::DIR_DOWN: result.rate_offset = -numer_n;
			default:           result.rate_offset = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q <= '0;
			ticks_q <= '0;
			numer_q <= '0;
			denom_q <= '0;
			dir_q   <= ddc_pkg::DIR_NONE;
			acc_q   <= '0;
			phase_q <= '0;
			last_q  <= '0;
		end else if (fire) begin
			clock_q <= clock_n;
			ticks_q <= ticks_n;
			numer_q <= numer_n;
			denom_q <= denom_n;
			dir_q   <= dir_n;
			acc_q   <= acc_n;
			phase_q <= phase_n;
			last_q  <= last_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ddc_out_reg.sv =====
// ----------------------------------------------------------------------------
// ddc_out_reg
// Result register holding one word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_out_reg (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          load,
	input  wire ddc_pkg::result_t result_n,
	input  wire logic          out_ready,
	output logic               out_valid,
	output ddc_pkg::result_t   result_q,
	output logic               free
);

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_q <= result_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/disciplined_day_clock.sv =====
// ----------------------------------------------------------------------------
// disciplined_day_clock
// Millisecond time-of-day clock with rate and phase discipline from
// reference time stamps.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless the output stalls, and returns one result
// word per input word through the input and result registers, with the clock
// and correction state update combinational between them. A tick word advances
// the clock by 0, 1 or 2 ms; a set-time word, when correction is enabled,
// either derives a new rate and phase correction or loads the reference. The
// correction enable must be written by the user only while idle; the block
// does not enforce it. Reset zeroes all state at once, with no clearing pass.
`default_nettype none

module disciplined_day_clock (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // reference_ms
	input  wire logic        s_tuser,   // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // time_of_day_ms, rate_offset
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data   // correction_enable
);

	localparam int unsigned TW = ddc_pkg::TIME_W;
	localparam int unsigned WW = ddc_pkg::WORD_W;

	logic               enable_q;
	ddc_pkg::item_t     in_item;
	ddc_pkg::item_t     item_s1;
	logic               valid_s1;
	logic               advance;
	ddc_pkg::result_t   result_n;
	ddc_pkg::result_t   result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid) begin
			enable_q <= cfg_data;
		end
	end

	assign in_item.command      = s_tuser;
	assign in_item.reference_ms = s_tdata[TW-1:0];

	ddc_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ddc_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance && valid_s1),
		.enable (enable_q),
		.item   (item_s1),
		.result (result_n)
	);

	ddc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result_n  (result_n),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.result_q  (result_q),
		.free      (advance)
	);

	assign m_tdata = {(48 - TW - WW)'(0), result_q.rate_offset, result_q.time_of_day_ms};

endmodule

`default_nettype wire

// ===== tb/disciplined_day_clock_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// disciplined_day_clock_tb
// Self-checking bench for the disciplined day clock.
// Ticks and reference stamps are streamed in bursts against a stalling
// receiver. A scoreboard class carries its own copy of the clock, rate and
// phase state and predicts every result word. Each predicted word is matched
// in order against the block. The run starts with directed words around
// midnight and the correction paths. It then drives a short tick run between
// stamps on the clock and random tracking sequences mixed with noise, at both
// enable settings.
// ----------------------------------------------------------------------------
`default_nettype none

module disciplined_day_clock_tb;

	localparam int DAY_INT     = int'(ddc_pkg::DAY_MS);
	localparam int NEAR_MS     = 10_000;
	localparam int LATENCY     = 2;
	localparam int HOLD_CYCLES = 400;
	localparam int STAMP_SPAN  = 2 ** ddc_pkg::TIME_W;

	class day_clock_scoreboard;
		bit                         enabled;
		logic [ddc_pkg::TIME_W-1:0] day_ms;
		logic [ddc_pkg::TICK_W-1:0] tick_count;
		logic [ddc_pkg::WORD_W-1:0] rate_num;
		logic [ddc_pkg::TICK_W-1:0] rate_den;
		logic [1:0]                 rate_dir;
		logic [ddc_pkg::WORD_W-1:0] rate_acc;
		logic [ddc_pkg::WORD_W-1:0] slew;
		logic [ddc_pkg::WORD_W-1:0] last_stamp_low;
		ddc_pkg::result_t           expected_q[$];
		int                         failures;
		int                         words_in;
		int                         words_out;
		int                         rate_updates;
		int                         loads;
		int                         ignored;

		function void note_config(bit value);
			enabled = value;
		endfunction

		function void note_item(logic cmd, logic [ddc_pkg::TIME_W-1:0] stamp);
			int                         step;
			int unsigned                nxt;
			int                         r;
			int                         d;
			logic [ddc_pkg::WORD_W-1:0] stamp_low;
			logic [ddc_pkg::WORD_W-1:0] dms;
			logic [ddc_pkg::WORD_W-1:0] num;
			ddc_pkg::result_t           want;
			words_in++;
			if (cmd == ddc_pkg::CMD_TICK) begin
				if (tick_count < ddc_pkg::TICK_LIMIT)
					tick_count++;
				rate_acc = rate_acc - rate_num;
				step = 1;
				if (rate_acc[ddc_pkg::WORD_W-1]) begin
					rate_acc = rate_acc + ddc_pkg::WORD_W'(rate_den);
					if (rate_dir == ddc_pkg::DIR_UP)
						step = 2;
					else if (rate_dir == ddc_pkg::DIR_DOWN)
						step = 0;
				end else if (!slew[ddc_pkg::WORD_W-1] && slew != '0) begin
					step = 2;
					slew = slew - 1'b1;
				end else if (slew[ddc_pkg::WORD_W-1]) begin
					step = 0;
					slew = slew + 1'b1;
				end
				nxt = day_ms + step;
				if (nxt >= ddc_pkg::DAY_MS)
					nxt = nxt - ddc_pkg::DAY_MS;
				day_ms = nxt[ddc_pkg::TIME_W-1:0];
			end else if (!enabled) begin
				ignored++;
			end else begin
				r = (stamp >= ddc_pkg::DAY_MS) ? int'(stamp) - DAY_INT : int'(stamp);
				d = r - int'(day_ms);
				// shortest way round the day
				if (d >= 0) begin
					if (d >= DAY_INT / 2)
						d = d - DAY_INT;
				end else if (d < -(DAY_INT / 2)) begin
					d = d + DAY_INT;
				end
				if (d < 0)
					d = -d;
				stamp_low = stamp[ddc_pkg::WORD_W-1:0];
				dms = stamp_low - last_stamp_low;
				if (tick_count < ddc_pkg::TICK_LIMIT && !dms[ddc_pkg::WORD_W-1]
						&& dms != '0 && d < NEAR_MS) begin
					num = dms - ddc_pkg::WORD_W'(tick_count);
					rate_den = tick_count;
					if (!num[ddc_pkg::WORD_W-1]) begin
						rate_num = num;
						rate_dir = ddc_pkg::DIR_UP;
					end else begin
						rate_num = -num;
						rate_dir = ddc_pkg::DIR_DOWN;
					end
					slew = stamp_low - day_ms[ddc_pkg::WORD_W-1:0];
					rate_updates++;
				end else begin
					day_ms = r[ddc_pkg::TIME_W-1:0];
					loads++;
				end
				last_stamp_low = stamp_low;
				tick_count = '0;
			end
			want.time_of_day_ms = day_ms;
			if (rate_dir == ddc_pkg::DIR_UP)
				want.rate_offset = rate_num;
			else if (rate_dir == ddc_pkg::DIR_DOWN)
				want.rate_offset = -rate_num;
			else
				want.rate_offset = '0;
			expected_q.push_back(want);
		endfunction

		function void check_word(logic [47:0] word);
			ddc_pkg::result_t got;
			ddc_pkg::result_t want;
			got = word[$bits(ddc_pkg::result_t)-1:0];
			words_out++;
			if (expected_q.size() == 0) begin
				if (failures < 10)
					$display("result word with nothing expected: time %0d offset %0d",
						got.time_of_day_ms, $signed(got.rate_offset));
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.time_of_day_ms !== want.time_of_day_ms
					|| got.rate_offset !== want.rate_offset) begin
				if (failures < 10)
					$display("mismatch on result %0d: time exp %0d got %0d, offset exp %0d got %0d",
						words_out, want.time_of_day_ms, got.time_of_day_ms,
						$signed(want.rate_offset), $signed(got.rate_offset));
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic        s_tuser   = ddc_pkg::CMD_TICK;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;

	day_clock_scoreboard sb = new();
	ddc_pkg::item_t      stim_q[$];
	int unsigned         stamp_clock;
	bit                  hold_request = 1'b0;

	disciplined_day_clock DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // reference_ms
		.s_tuser   (s_tuser),   // command
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // time_of_day_ms, rate_offset
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)   // correction_enable
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.note_config(cfg_data);
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata[ddc_pkg::TIME_W-1:0]);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata);
		end
	end

	// receiver: random ready runs and stalls, quiet stretches, one long hold
	initial begin : result_sink
		int run;
		@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready = 1'b1;
				run = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 16);
				repeat (run) @(negedge clk);
				run = $urandom_range(0, 6);
				if (run > 0) begin
					m_tready = 1'b0;
					repeat (run) @(negedge clk);
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic void push_word(logic cmd, int unsigned stamp);
		ddc_pkg::item_t w;
		w.command      = cmd;
		w.reference_ms = stamp[ddc_pkg::TIME_W-1:0];
		stim_q.push_back(w);
	endfunction

	task automatic drive_items();
		int             burst;
		int             gap;
		ddc_pkg::item_t w;
		burst = 0;
		while (stim_q.size() > 0) begin
			if (burst == 0) begin
				burst = ($urandom_range(0, 4) == 0) ? 100 : $urandom_range(1, 24);
				gap = $urandom_range(0, 7);
				if (gap > 0) begin
					@(negedge clk);
					s_tvalid = 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
			end
			w = stim_q.pop_front();
			@(negedge clk);
			s_tvalid = 1'b1;
			s_tuser  = w.command;
			s_tdata  = {{(32 - ddc_pkg::TIME_W){1'b0}}, w.reference_ms};
			do @(posedge clk); while (!s_tready);
			burst--;
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_enable(bit value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// mostly tick runs closed by a stamp that tracks a drifting reference
	task automatic queue_random(int count);
		int          sel;
		int          n;
		int          delta;
		int unsigned stamp;
		while (stim_q.size() < count) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				n = $urandom_range(1, 40);
				repeat (n) push_word(ddc_pkg::CMD_TICK, $urandom_range(0, STAMP_SPAN - 1));
				delta = n + $urandom_range(0, 6) - 3;
				if (delta < 1)
					delta = 1;
				stamp_clock = (stamp_clock + delta) % DAY_INT;
				stamp = stamp_clock;
				if ($urandom_range(0, 7) == 0 && stamp < STAMP_SPAN - DAY_INT)
					stamp = stamp + DAY_INT;
				push_word(ddc_pkg::CMD_SET, stamp);
			end else if (sel == 7) begin
				n = $urandom_range(1, 5);
				repeat (n) push_word(1'($urandom_range(0, 1)),
					$urandom_range(0, STAMP_SPAN - 1));
			end else if (sel == 8) begin
				// stamp repeated or behind the last one
				push_word(ddc_pkg::CMD_SET,
					(stamp_clock + DAY_INT - $urandom_range(0, 20)) % DAY_INT);
			end else begin
				// back-to-back stamps, nothing ticked in between
				stamp_clock = (stamp_clock + 1) % DAY_INT;
				push_word(ddc_pkg::CMD_SET, stamp_clock);
				stamp_clock = (stamp_clock + 1) % DAY_INT;
				push_word(ddc_pkg::CMD_SET, stamp_clock);
			end
		end
	endtask

	initial begin
		int unsigned sync_stamp;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// correction off from reset: stamps leave everything alone
		push_word(ddc_pkg::CMD_TICK, 0);
		push_word(ddc_pkg::CMD_SET, 0);
		push_word(ddc_pkg::CMD_SET, DAY_INT - 1);
		push_word(ddc_pkg::CMD_SET, STAMP_SPAN - 1);
		push_word(ddc_pkg::CMD_TICK, STAMP_SPAN - 1);
		push_word(ddc_pkg::CMD_TICK, 0);
		drive_items();
		wait_idle();

		write_enable(1'b1);
		// stamp just before midnight, near the clock across it, ticks, then correct from beyond-day stamps
		push_word(ddc_pkg::CMD_SET, DAY_INT - 5);
		repeat (8) push_word(ddc_pkg::CMD_TICK, 0);
		push_word(ddc_pkg::CMD_SET, DAY_INT + 5);
		push_word(ddc_pkg::CMD_SET, DAY_INT + 10);
		repeat (3) push_word(ddc_pkg::CMD_TICK, 0);
		// stamp behind the last one, near the clock the other way round midnight
		push_word(ddc_pkg::CMD_SET, DAY_INT - 10);
		repeat (4) push_word(ddc_pkg::CMD_TICK, 0);
		// fewer ms than ticks: rate runs slow
		push_word(ddc_pkg::CMD_SET, DAY_INT - 9);
		repeat (3) push_word(ddc_pkg::CMD_TICK, 0);
		push_word(ddc_pkg::CMD_SET, 0);
		push_word(ddc_pkg::CMD_SET, STAMP_SPAN - 1);
		push_word(ddc_pkg::CMD_TICK, 0);
		drive_items();
		wait_idle();

		// a stamp right on the clock, a tick run, then a stamp just ahead
		sync_stamp = 32'(sb.day_ms);
		push_word(ddc_pkg::CMD_SET, sync_stamp);
		repeat (40) push_word(ddc_pkg::CMD_TICK, $urandom_range(0, STAMP_SPAN - 1));
		drive_items();
		wait_idle();
		push_word(ddc_pkg::CMD_SET, (sb.day_ms + 1) % DAY_INT);
		drive_items();
		wait_idle();

		stamp_clock = $urandom_range(0, DAY_INT - 1);
		queue_random(110);
		drive_items();
		wait_idle();
		queue_random(110);
		drive_items();
		wait_idle();

		write_enable(1'b0);
		queue_random(90);
		drive_items();
		wait_idle();

		write_enable(1'b1);
		stamp_clock = DAY_INT - $urandom_range(100, 3000);
		hold_request = 1'b1;
		queue_random(220);
		drive_items();
		wait_idle();

		if (sb.pending() > 0) begin
			$display("%0d expected result words never arrived", sb.pending());
			sb.failures += sb.pending();
		end
		$display("covered %0d input words and %0d result words; %0d rate updates, %0d loads",
			sb.words_in, sb.words_out, sb.rate_updates, sb.loads);
		$display("%0d stamps ignored with correction off, %0d mismatches",
			sb.ignored, sb.failures);
		if (sb.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ddc_pkg.sv
rtl/ddc_in_reg.sv
rtl/ddc_update.sv
rtl/ddc_out_reg.sv
rtl/disciplined_day_clock.sv
tb/disciplined_day_clock_tb.sv
